// ===== hw/rtl/can_rx_id_demux_mailbox_defines.svh =====
// assertion macros for the can receive mailbox
// used by crxmb_queue and crxmb_back, empty when synthesising
`ifndef CAN_RX_ID_DEMUX_MAILBOX_DEFINES_SVH
`define CAN_RX_ID_DEMUX_MAILBOX_DEFINES_SVH

`ifndef SYNTHESIS
`define CRXMB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRXMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CRXMB_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRXMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/crxmb_pkg.sv =====
// types and constants of the can receive mailbox
// no dependencies
`default_nettype none

package crxmb_pkg;

  localparam int unsigned NUM_ROUTES = 8;
  localparam int unsigned ROUTE_IW   = $clog2(NUM_ROUTES);
  localparam int unsigned CFG_DW     = 16;

  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [3:0]  MAX_BYTES = 4'd8;
  localparam logic [31:0] NEVER_AGE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        valid;
    logic [10:0] id;
    logic [3:0]  slot;
  } route_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STORE,
    OP_TICK,
    OP_READ,
    OP_READ_OOR
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  slot;
    logic [3:0]  len;
    logic [63:0] data;
  } cmd_t;

  typedef struct packed {
    logic        matched;
    logic [3:0]  hit_slot;
    logic [63:0] slot_data;
    logic [3:0]  slot_len;
    logic        slot_seen;
    logic [31:0] slot_age;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/crxmb_if.sv =====
// request and result channel interfaces of the can receive mailbox
// valid/ready handshake with payload, no dependencies
`default_nettype none

interface crxmb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [10:0] frame_id;
  logic [3:0]  frame_len;
  logic [63:0] frame_data;
  logic [3:0]  read_slot;

  modport source (output valid, req_type, frame_id, frame_len, frame_data, read_slot,
                  input ready);
  modport sink (input valid, req_type, frame_id, frame_len, frame_data, read_slot,
                output ready);
endinterface

interface crxmb_rsp_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [3:0]  hit_slot;
  logic [63:0] slot_data;
  logic [3:0]  slot_len;
  logic        slot_seen;
  logic [31:0] slot_age;

  modport source (output valid, matched, hit_slot, slot_data, slot_len, slot_seen, slot_age,
                  input ready);
  modport sink (input valid, matched, hit_slot, slot_data, slot_len, slot_seen, slot_age,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/can_rx_id_demux_mailbox.sv =====
// an accepted request is written into the command queue, then moved into the result register once that register is free
// throughput: one request per cycle sustained while results are taken without stall, set by the single-port slot unit
// a two-entry command queue decouples the route match from the slot unit
// reset: routes invalid, seen marks and the millisecond counter cleared
// slots read as empty until written, no clearing pass
`default_nettype none

module can_rx_id_demux_mailbox #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crxmb_pkg::ROUTE_IW-1:0]  cfg_idx_i,
  input  logic [crxmb_pkg::CFG_DW-1:0]    cfg_wdata_i,
  crxmb_req_if.sink                       req_i,
  crxmb_rsp_if.source                     rsp_o
);

  logic            q_push, q_full, q_pop, q_empty;
  crxmb_pkg::cmd_t q_cmd_in, q_cmd_out;

  crxmb_front #(.SLOTS(SLOTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in)
  );

  crxmb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd_out)
  );

  crxmb_back #(.SLOTS(SLOTS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_cmd_out),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/crxmb_front.sv =====
// front end: route registers, identifier match and request classification
// depends on crxmb_pkg and crxmb_req_if
`default_nettype none

module crxmb_front #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crxmb_pkg::ROUTE_IW-1:0]  cfg_idx_i,
  input  logic [crxmb_pkg::CFG_DW-1:0]    cfg_wdata_i,
  crxmb_req_if.sink                       req_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output crxmb_pkg::cmd_t                 q_cmd_o
);

  localparam logic [4:0] SLOT_LIM = 5'(SLOTS);

  crxmb_pkg::route_t route_q [crxmb_pkg::NUM_ROUTES];
  crxmb_pkg::route_t hit_route;
  logic              hit;
  logic [3:0]        len_clamp;
  logic [63:0]       data_kept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < crxmb_pkg::NUM_ROUTES; i++) route_q[i] <= '0;
    end else if (cfg_we_i) begin
      route_q[cfg_idx_i] <= crxmb_pkg::route_t'(cfg_wdata_i);
    end
  end

  // lowest route index wins
  always_comb begin
    hit       = 1'b0;
    hit_route = '0;
    for (int i = crxmb_pkg::NUM_ROUTES - 1; i >= 0; i--) begin
      if (route_q[i].valid && (route_q[i].id == req_i.frame_id)) begin
        hit       = 1'b1;
        hit_route = route_q[i];
      end
    end
  end

  always_comb begin
    len_clamp = (req_i.frame_len > crxmb_pkg::MAX_BYTES) ? crxmb_pkg::MAX_BYTES
                                                          : req_i.frame_len;
    for (int b = 0; b < 8; b++) begin
      data_kept[b*8 +: 8] = (4'(b) < len_clamp) ? req_i.frame_data[b*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    q_cmd_o = '0;
    unique case (req_i.req_type)
      crxmb_pkg::REQ_FRAME: begin
        if (hit && ({1'b0, hit_route.slot} < SLOT_LIM)) begin
          q_cmd_o.op   = crxmb_pkg::OP_STORE;
          q_cmd_o.slot = hit_route.slot;
          q_cmd_o.len  = len_clamp;
          q_cmd_o.data = data_kept;
        end
      end
      crxmb_pkg::REQ_TICK: begin
        q_cmd_o.op = crxmb_pkg::OP_TICK;
      end
      crxmb_pkg::REQ_READ: begin
        q_cmd_o.slot = req_i.read_slot;
        q_cmd_o.op   = ({1'b0, req_i.read_slot} < SLOT_LIM) ? crxmb_pkg::OP_READ
                                                             : crxmb_pkg::OP_READ_OOR;
      end
      default: begin
        q_cmd_o.op = crxmb_pkg::OP_NONE;
      end
    endcase
  end

  assign req_i.ready = !q_full_i;
  assign q_push_o    = req_i.valid && !q_full_i;

endmodule

`default_nettype wire

// ===== hw/rtl/crxmb_queue.sv =====
// two-entry command queue between front end and slot unit
// depends on crxmb_pkg and the assertion macros
`default_nettype none
`include "can_rx_id_demux_mailbox_defines.svh"

module crxmb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  crxmb_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output crxmb_pkg::cmd_t cmd_o
);

  localparam int unsigned DEPTH = 2;

  crxmb_pkg::cmd_t mem_q [DEPTH];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `CRXMB_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= 2'(DEPTH), "queue count past depth")
  `CRXMB_ASSERT_NEXT(a_cnt_grow, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 2'd1, "queue count did not grow")

endmodule

`default_nettype wire

// ===== hw/rtl/crxmb_back.sv =====
// slot unit: mailbox slot store, millisecond counter and result register
// depends on crxmb_pkg, crxmb_rsp_if and the assertion macros
`default_nettype none
`include "can_rx_id_demux_mailbox_defines.svh"

module crxmb_back #(
  parameter int unsigned SLOTS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  crxmb_pkg::cmd_t q_cmd_i,
  output logic            q_pop_o,
  crxmb_rsp_if.source     rsp_o
);

  localparam int unsigned SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [63:0]        payload_q [SLOTS];
  logic [3:0]         len_q     [SLOTS];
  logic [31:0]        time_q    [SLOTS];
  logic [SLOTS-1:0]   seen_q;
  logic [31:0]        now_q, now_d;
  logic               out_valid_q, out_valid_d;
  crxmb_pkg::res_t    res_q, res_d;
  logic [SLOT_AW-1:0] idx;
  logic               pop;

  assign idx     = q_cmd_i.slot[SLOT_AW-1:0];
  assign pop     = !q_empty_i && (!out_valid_q || rsp_o.ready);
  assign q_pop_o = pop;

  always_comb begin
    res_d = '0;
    now_d = now_q;
    case (q_cmd_i.op)
      crxmb_pkg::OP_STORE: begin
        res_d.matched  = 1'b1;
        res_d.hit_slot = q_cmd_i.slot;
      end
      crxmb_pkg::OP_TICK: begin
        now_d = now_q + 32'd1;
      end
      crxmb_pkg::OP_READ: begin
        res_d.hit_slot  = q_cmd_i.slot;
        res_d.slot_seen = seen_q[idx];
        res_d.slot_data = seen_q[idx] ? payload_q[idx] : 64'd0;
        res_d.slot_len  = seen_q[idx] ? len_q[idx] : 4'd0;
        res_d.slot_age  = seen_q[idx] ? (now_q - time_q[idx]) : crxmb_pkg::NEVER_AGE;
      end
      crxmb_pkg::OP_READ_OOR: begin
        res_d.hit_slot = q_cmd_i.slot;
        res_d.slot_age = crxmb_pkg::NEVER_AGE;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_comb begin
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      now_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        now_q <= now_d;
        if (q_cmd_i.op == crxmb_pkg::OP_STORE) begin
          seen_q[idx] <= 1'b1;
        end
      end
    end
  end

  // slot payload only meaningful once its seen mark is set
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
      if (q_cmd_i.op == crxmb_pkg::OP_STORE) begin
        payload_q[idx] <= q_cmd_i.data;
        len_q[idx]     <= q_cmd_i.len;
        time_q[idx]    <= now_q;
      end
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.matched   = res_q.matched;
  assign rsp_o.hit_slot  = res_q.hit_slot;
  assign rsp_o.slot_data = res_q.slot_data;
  assign rsp_o.slot_len  = res_q.slot_len;
  assign rsp_o.slot_seen = res_q.slot_seen;
  assign rsp_o.slot_age  = res_q.slot_age;

  `CRXMB_ASSERT_NEXT(a_tick_adv, clk_i, rst_ni, pop && (q_cmd_i.op == crxmb_pkg::OP_TICK), now_q == $past(now_q) + 32'd1, "tick did not advance time")
  `CRXMB_ASSERT(a_frame_res, clk_i, rst_ni, out_valid_q && res_q.matched |-> !res_q.slot_seen && (res_q.slot_age == 32'd0), "frame result carries slot fields")

endmodule

`default_nettype wire

// ===== bench/can_rx_id_demux_mailbox_tb.sv =====
`timescale 1ns / 1ps
// testbench of can_rx_id_demux_mailbox: routed frame stores, millisecond ticks and slot reads
// predicts every result with its own mailbox model, checks each one as it comes out
// depends on crxmb_pkg, crxmb_if and the mailbox rtl
module can_rx_id_demux_mailbox_tb;

  localparam int unsigned SLOT_COUNT    = 8;
  localparam logic [1:0]  REQ_SPARE     = 2'd3;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 230;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    logic [3:0]  slot;
  } can_req_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [crxmb_pkg::ROUTE_IW-1:0] cfg_idx_i;
  logic [crxmb_pkg::CFG_DW-1:0]   cfg_wdata_i;

  crxmb_req_if req_if ();
  crxmb_rsp_if rsp_if ();

  can_rx_id_demux_mailbox #(
    .SLOTS(SLOT_COUNT)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  crxmb_pkg::route_t route_copy   [crxmb_pkg::NUM_ROUTES];
  logic [15:0]       route_plan   [crxmb_pkg::NUM_ROUTES];
  logic [63:0]       payload_copy [SLOT_COUNT];
  logic [3:0]        length_copy  [SLOT_COUNT];
  logic [31:0]       stamp_copy   [SLOT_COUNT];
  logic              seen_copy    [SLOT_COUNT];
  logic [31:0]       now_copy;

  crxmb_pkg::res_t pending_results [$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  bit              steady = 1'b0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("can_rx_id_demux_mailbox_tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned idle_span();
    if ($urandom_range(0, 9) < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic can_req_t make_req(logic [1:0] kind, logic [10:0] id, logic [3:0] len,
                                        logic [63:0] data, logic [3:0] slot);
    can_req_t rq;
    rq.kind = kind;
    rq.id   = id;
    rq.len  = len;
    rq.data = data;
    rq.slot = slot;
    return rq;
  endfunction

  function automatic crxmb_pkg::res_t mailbox_outcome(can_req_t rq);
    crxmb_pkg::res_t r;
    logic            found;
    logic [3:0]      target;
    logic [3:0]      kept;
    r     = '0;
    found = 1'b0;
    case (rq.kind)
      crxmb_pkg::REQ_FRAME: begin
        for (int i = 0; i < crxmb_pkg::NUM_ROUTES; i++) begin
          if (!found && route_copy[i].valid && route_copy[i].id == rq.id) begin
            found  = 1'b1;
            target = route_copy[i].slot;
            if (target < SLOT_COUNT) begin
              kept = (rq.len > crxmb_pkg::MAX_BYTES) ? crxmb_pkg::MAX_BYTES : rq.len;
              payload_copy[target] = (kept >= crxmb_pkg::MAX_BYTES) ? rq.data
                                   : rq.data & ((64'd1 << (8 * kept)) - 64'd1);
              length_copy[target]  = kept;
              stamp_copy[target]   = now_copy;
              seen_copy[target]    = 1'b1;
              r.matched  = 1'b1;
              r.hit_slot = target;
            end
          end
        end
      end
      crxmb_pkg::REQ_TICK: begin
        now_copy = now_copy + 32'd1;
      end
      crxmb_pkg::REQ_READ: begin
        r.hit_slot = rq.slot;
        r.slot_age = crxmb_pkg::NEVER_AGE;
        if (rq.slot < SLOT_COUNT) begin
          r.slot_data = payload_copy[rq.slot];
          r.slot_len  = length_copy[rq.slot];
          r.slot_seen = seen_copy[rq.slot];
          if (seen_copy[rq.slot]) begin
            r.slot_age = now_copy - stamp_copy[rq.slot];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (mismatch_count < MAX_REPORTS) begin
        $display("%s mismatch at cycle %0d: expected %h, got %h", field, cycle_count, want, got);
      end
      mismatch_count++;
    end
  endtask

  initial begin : result_check
    int unsigned     stall_left;
    crxmb_pkg::res_t want;
    crxmb_pkg::res_t got;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        got.matched   = rsp_if.matched;
        got.hit_slot  = rsp_if.hit_slot;
        got.slot_data = rsp_if.slot_data;
        got.slot_len  = rsp_if.slot_len;
        got.slot_seen = rsp_if.slot_seen;
        got.slot_age  = rsp_if.slot_age;
        if (pending_results.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("result with nothing pending at cycle %0d: slot %0d", cycle_count,
                     got.hit_slot);
          end
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("matched", want.matched, got.matched);
          check_field("hit_slot", want.hit_slot, got.hit_slot);
          check_field("slot_data", want.slot_data, got.slot_data);
          check_field("slot_len", want.slot_len, got.slot_len);
          check_field("slot_seen", want.slot_seen, got.slot_seen);
          check_field("slot_age", want.slot_age, got.slot_age);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        rsp_if.ready <= 1'b1;
      end else begin
        stall_left = idle_span() - 1;
        rsp_if.ready <= 1'b0;
      end
    end
  end

  // valid stays high across back-to-back requests, lowered only for a gap
  task automatic send_request(can_req_t rq);
    int unsigned gap;
    req_if.valid      <= 1'b1;
    req_if.req_type   <= rq.kind;
    req_if.frame_id   <= rq.id;
    req_if.frame_len  <= rq.len;
    req_if.frame_data <= rq.data;
    req_if.read_slot  <= rq.slot;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    pending_results.push_back(mailbox_outcome(rq));
    if (!steady && $urandom_range(0, 2) == 0) begin
      gap = idle_span();
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle_mailbox();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_routes();
    for (int i = 0; i < crxmb_pkg::NUM_ROUTES; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[crxmb_pkg::ROUTE_IW-1:0];
      cfg_wdata_i <= route_plan[i];
      @(posedge clk_i);
      route_copy[i] = crxmb_pkg::route_t'(route_plan[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_empty_mailbox();
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h7FF, 4'd15, '1, 4'd7));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd8));
    send_request(make_req(crxmb_pkg::REQ_FRAME, 11'h000, 4'd8, '1, 4'd15));
    send_request(make_req(crxmb_pkg::REQ_TICK, 11'h7FF, 4'd15, '1, 4'd15));
    send_request(make_req(REQ_SPARE, 11'h7FF, 4'd15, '1, 4'd3));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd15));
  endtask

  task automatic test_routed_frames();
    settle_mailbox();
    route_plan[0] = {1'b1, 11'h123, 4'd2};
    route_plan[1] = {1'b1, 11'h000, 4'd0};
    route_plan[2] = {1'b1, 11'h7FF, 4'd7};
    route_plan[3] = {1'b1, 11'h2AA, 4'd9};
    route_plan[4] = {1'b1, 11'h123, 4'd5};
    route_plan[5] = {1'b1, 11'h2AA, 4'd4};
    route_plan[6] = {1'b0, 11'h555, 4'd1};
    route_plan[7] = {1'b1, 11'h555, 4'd6};
    load_routes();
    // top priority wins, out of range slot drops, invalid route skipped
    send_request(make_req(crxmb_pkg::REQ_FRAME, 11'h123, 4'd8, '1, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_FRAME, 11'h000, 4'd0, '1, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_FRAME, 11'h7FF, 4'd15,
                          64'h0123_4567_89AB_CDEF, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_FRAME, 11'h2AA, 4'd4, '1, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_FRAME, 11'h555, 4'd3,
                          64'hFEDC_BA98_7654_3210, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_FRAME, 11'h456, 4'd8, '1, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_TICK, 11'h000, 4'd0, '0, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_TICK, 11'h000, 4'd0, '0, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd2));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd7));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd6));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd4));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd9));
    send_request(make_req(crxmb_pkg::REQ_FRAME, 11'h123, 4'd1, '1, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_TICK, 11'h000, 4'd0, '0, 4'd0));
    send_request(make_req(crxmb_pkg::REQ_READ, 11'h000, 4'd0, '0, 4'd2));
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    logic [10:0] id;
    logic [3:0]  slot;
    logic [1:0]  kind;
    for (int p = 0; p < PHASES; p++) begin
      settle_mailbox();
      if (p == PHASES - 1) begin
        // all ones, all zeros, valid bit alone and shadowed entries
        route_plan = '{16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000,
                       16'h800F, 16'hFFF7, 16'h8017, 16'h0000};
      end else begin
        for (int i = 0; i < crxmb_pkg::NUM_ROUTES; i++) begin
          id   = ($urandom_range(0, 1) == 0) ? 11'($urandom) : 11'($urandom_range(0, 7));
          slot = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, SLOT_COUNT - 1))
                                               : 4'($urandom_range(SLOT_COUNT, 15));
          route_plan[i] = {($urandom_range(0, 99) < 85), id, slot};
        end
      end
      load_routes();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) != 0) begin
          id = route_copy[$urandom_range(0, crxmb_pkg::NUM_ROUTES - 1)].id;
        end else begin
          id = 11'($urandom);
        end
        slot = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, SLOT_COUNT - 1))
                                             : 4'($urandom_range(SLOT_COUNT, 15));
        kind = (pick < 45) ? crxmb_pkg::REQ_FRAME :
               (pick < 65) ? crxmb_pkg::REQ_TICK :
               (pick < 95) ? crxmb_pkg::REQ_READ : REQ_SPARE;
        send_request(make_req(kind, id, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                              slot));
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_wdata_i       <= '0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= crxmb_pkg::REQ_FRAME;
    req_if.frame_id   <= '0;
    req_if.frame_len  <= '0;
    req_if.frame_data <= '0;
    req_if.read_slot  <= '0;
    for (int i = 0; i < crxmb_pkg::NUM_ROUTES; i++) begin
      route_copy[i] = '0;
    end
    for (int s = 0; s < SLOT_COUNT; s++) begin
      payload_copy[s] = '0;
      length_copy[s]  = '0;
      stamp_copy[s]   = '0;
      seen_copy[s]    = 1'b0;
    end
    now_copy = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_mailbox();
    test_routed_frames();
    test_random_traffic();
    settle_mailbox();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("can_rx_id_demux_mailbox_tb: PASS");
    end else begin
      $display("can_rx_id_demux_mailbox_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/crxmb_pkg.sv
hw/rtl/crxmb_if.sv
hw/rtl/crxmb_front.sv
hw/rtl/crxmb_queue.sv
hw/rtl/crxmb_back.sv
hw/rtl/can_rx_id_demux_mailbox.sv
bench/can_rx_id_demux_mailbox_tb.sv
